>>> rtl/point_in_polygon_tester_core_assert.svh
// ----------------------------------------------------------------------------
// Point-in-polygon tester assertion macros
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TESTER_CORE_ASSERT_SVH
`define POINT_IN_POLYGON_TESTER_CORE_ASSERT_SVH

// same-cycle implication
`define PIPT_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PIPT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/pipt_pkg.sv
// ----------------------------------------------------------------------------
// pipt_pkg
// Shared codes and types of the point-in-polygon tester.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pipt_pkg;

   // item kinds on the request side
   localparam logic [1:0] KIND_POINT  = 2'd0;
   localparam logic [1:0] KIND_BOX    = 2'd1;
   localparam logic [1:0] KIND_VERTEX = 2'd2;

   // rings with fewer points are ignored
   localparam int unsigned MIN_RING_POINTS = 4;

   localparam int EDGE_DEPTH = 4;
   localparam int RSP_DEPTH  = 8;

   typedef enum logic [1:0] {
      LOC_OUTSIDE  = 2'd0,
      LOC_INSIDE   = 2'd1,
      LOC_BOUNDARY = 2'd2
   } loc_type;

   // work handed from the front to the back
   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,   // no flag change
      OP_CLEAR = 3'd1,   // new query point
      OP_UP    = 3'd2,   // upward straddle: toggle on positive cross
      OP_DOWN  = 3'd3,   // downward straddle: toggle on negative cross
      OP_TOUCH = 3'd4,   // one end on the scan line: boundary on zero cross
      OP_BOUND = 3'd5    // horizontal edge through the point
   } op_type;

   typedef struct packed {
      op_type op;
      logic   last;
      logic   outside;
   } ctrl_type;

endpackage

>>> rtl/pipt_queue.sv
// ----------------------------------------------------------------------------
// pipt_queue
// Small register FIFO with fill count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pipt_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             wr_data,
   output logic                         full,
   input  logic                         pop,
   output logic [WIDTH-1:0]             rd_data,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign count   = count_ff;
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> rtl/pipt_front.sv
// ----------------------------------------------------------------------------
// pipt_front
// Takes request words, keeps query/ring state and classifies each edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pipt_front import pipt_pkg::*; #(
   parameter int COORD_BITS = 32,
   parameter int COUNT_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [1:0]                    kind,
   input  logic signed [COORD_BITS-1:0]  coord_x,
   input  logic signed [COORD_BITS-1:0]  coord_y,
   input  logic signed [COORD_BITS-1:0]  coord_x2,
   input  logic signed [COORD_BITS-1:0]  coord_y2,
   input  logic                          first_in_ring,
   input  logic [COUNT_BITS-1:0]         ring_points,
   input  logic                          last,
   output ctrl_type                      word_ctrl,
   output logic [COORD_BITS:0]           word_u1,
   output logic [COORD_BITS:0]           word_v1,
   output logic [COORD_BITS:0]           word_u2,
   output logic [COORD_BITS:0]           word_v2
);

   localparam int DW = COORD_BITS + 1;

   logic signed [COORD_BITS-1:0] qx_ff, qx_in, qy_ff, qy_in;
   logic [DW-1:0]                pdx_ff, pdx_in, pdy_ff, pdy_in;
   logic                         outside_ff, outside_in, skip_ff, skip_in;
   logic [DW-1:0]                dx, dy;
   logic                         box_hit;
   logic                         v1_neg, v1_zero, v1_pos, v2_neg, v2_zero, v2_pos;
   logic                         u1_neg, u1_pos, u2_neg, u2_pos;
   op_type                       edge_op;

   // vertex relative to the query point, exact in DW bits
   assign dx = {coord_x[COORD_BITS-1], coord_x} - {qx_ff[COORD_BITS-1], qx_ff};
   assign dy = {coord_y[COORD_BITS-1], coord_y} - {qy_ff[COORD_BITS-1], qy_ff};

   assign box_hit = (qx_ff >= coord_x) && (coord_x2 >= qx_ff) &&
                    (qy_ff >= coord_y) && (coord_y2 >= qy_ff);

   assign v1_neg  = pdy_ff[DW-1];
   assign v1_zero = (pdy_ff == '0);
   assign v1_pos  = !v1_neg && !v1_zero;
   assign v2_neg  = dy[DW-1];
   assign v2_zero = (dy == '0);
   assign v2_pos  = !v2_neg && !v2_zero;
   assign u1_neg  = pdx_ff[DW-1];
   assign u1_pos  = !u1_neg && (pdx_ff != '0);
   assign u2_neg  = dx[DW-1];
   assign u2_pos  = !u2_neg && (dx != '0);

   always_comb begin
      edge_op = OP_NONE;
      priority if ((v1_neg && v2_neg) || (v1_pos && v2_pos)) begin
         edge_op = OP_NONE;
      end else if (v2_pos && !v1_pos) begin
         edge_op = OP_UP;
      end else if (v1_pos && !v2_pos) begin
         edge_op = OP_DOWN;
      end else if ((v2_zero && v1_neg) || (v1_zero && v2_neg)) begin
         edge_op = OP_TOUCH;
      end else if (v1_zero && v2_zero) begin
         // horizontal edge on the scan line: on it if the ends bracket x
         if ((!u2_pos && !u1_neg) || (!u1_pos && !u2_neg)) begin
            edge_op = OP_BOUND;
         end
      end else begin
         edge_op = OP_NONE;
      end
   end

   always_comb begin
      qx_in      = qx_ff;
      qy_in      = qy_ff;
      pdx_in     = pdx_ff;
      pdy_in     = pdy_ff;
      outside_in = outside_ff;
      skip_in    = skip_ff;
      word_ctrl  = '{op: OP_NONE, last: last, outside: 1'b0};
      unique case (kind)
         KIND_POINT: begin
            qx_in          = coord_x;
            qy_in          = coord_y;
            outside_in     = 1'b0;
            skip_in        = 1'b0;
            word_ctrl.op   = OP_CLEAR;
         end
         KIND_BOX: begin
            if (!box_hit) begin
               outside_in = 1'b1;
            end
         end
         KIND_VERTEX: begin
            pdx_in = dx;
            pdy_in = dy;
            if (first_in_ring) begin
               skip_in = (ring_points < COUNT_BITS'(MIN_RING_POINTS));
            end else if (!skip_ff) begin
               word_ctrl.op = edge_op;
            end
         end
         default: begin
         end
      endcase
      word_ctrl.outside = outside_in;
      if (last) begin
         outside_in = 1'b0;
         skip_in    = 1'b0;
      end
   end

   assign word_u1 = pdx_ff;
   assign word_v1 = pdy_ff;
   assign word_u2 = dx;
   assign word_v2 = dy;

   always_ff @(posedge clock) begin
      if (reset) begin
         qx_ff      <= '0;
         qy_ff      <= '0;
         pdx_ff     <= '0;
         pdy_ff     <= '0;
         outside_ff <= 1'b0;
         skip_ff    <= 1'b0;
      end else if (accept) begin
         qx_ff      <= qx_in;
         qy_ff      <= qy_in;
         pdx_ff     <= pdx_in;
         pdy_ff     <= pdy_in;
         outside_ff <= outside_in;
         skip_ff    <= skip_in;
      end
   end

endmodule

>>> rtl/pipt_back.sv
// ----------------------------------------------------------------------------
// pipt_back
// Cross-product sign pipeline, parity/boundary flags and result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pipt_back import pipt_pkg::*; #(
   parameter int COORD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_empty,
   output logic                  q_pop,
   input  ctrl_type              q_ctrl,
   input  logic [COORD_BITS:0]   q_u1,
   input  logic [COORD_BITS:0]   q_v1,
   input  logic [COORD_BITS:0]   q_u2,
   input  logic [COORD_BITS:0]   q_v2,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [1:0]            rsp_location
);

`include "point_in_polygon_tester_core_assert.svh"

   localparam int W   = COORD_BITS + 1;
   localparam int K   = (W + 1) / 2;      // low slice, unsigned
   localparam int HW  = W - K;            // high slice, signed
   localparam int XW  = 2 * W + 1;        // exact cross product
   localparam int RCW = $clog2(RSP_DEPTH + 1);
   localparam int FW  = RCW + 1;

   // stage 1: partial products of u1*v2 (p1) and u2*v1 (p2)
   logic                     s1_valid_ff;
   ctrl_type                 c1_ff;
   logic [2*K-1:0]           ll1_ff, ll1_in, ll2_ff, ll2_in;
   logic signed [W:0]        lh1_ff, lh1_in, hl1_ff, hl1_in;
   logic signed [W:0]        lh2_ff, lh2_in, hl2_ff, hl2_in;
   logic signed [2*HW-1:0]   hh1_ff, hh1_in, hh2_ff, hh2_in;
   // stage 2: differences per weight
   logic                     s2_valid_ff;
   ctrl_type                 c2_ff;
   logic signed [2*K:0]      dll_ff, dll_in;
   logic signed [W+2:0]      dmid_ff, dmid_in;
   logic signed [2*HW:0]     dhh_ff, dhh_in;
   // stage 3: full cross product
   logic                     s3_valid_ff;
   ctrl_type                 c3_ff;
   logic [XW-1:0]            cross_ff, cross_in;
   logic [XW-1:0]            ll_ext, mid_ext, hh_ext;
   // flags and result
   logic                     bound_ff, bound_in, parity_ff, parity_in;
   logic                     cr_neg, cr_zero, cr_pos;
   logic                     rsp_push, rsp_full;
   loc_type                  loc;
   logic [RCW-1:0]           rsp_count;
   logic [FW-1:0]            fill;

   // issue only when the result queue has room for everything in flight
   assign fill  = FW'(rsp_count) + FW'(s1_valid_ff) + FW'(s2_valid_ff) + FW'(s3_valid_ff);
   assign q_pop = !q_empty && (fill < FW'(RSP_DEPTH));

   assign ll1_in = q_u1[K-1:0] * q_v2[K-1:0];
   assign lh1_in = $signed({1'b0, q_u1[K-1:0]}) * $signed(q_v2[W-1:K]);
   assign hl1_in = $signed(q_u1[W-1:K]) * $signed({1'b0, q_v2[K-1:0]});
   assign hh1_in = $signed(q_u1[W-1:K]) * $signed(q_v2[W-1:K]);
   assign ll2_in = q_u2[K-1:0] * q_v1[K-1:0];
   assign lh2_in = $signed({1'b0, q_u2[K-1:0]}) * $signed(q_v1[W-1:K]);
   assign hl2_in = $signed(q_u2[W-1:K]) * $signed({1'b0, q_v1[K-1:0]});
   assign hh2_in = $signed(q_u2[W-1:K]) * $signed(q_v1[W-1:K]);

   assign dll_in  = $signed({1'b0, ll1_ff}) - $signed({1'b0, ll2_ff});
   assign dmid_in = lh1_ff + hl1_ff - lh2_ff - hl2_ff;
   assign dhh_in  = hh1_ff - hh2_ff;

   assign ll_ext   = {{(XW-2*K-1){dll_ff[2*K]}}, dll_ff};
   assign mid_ext  = {{(XW-W-3){dmid_ff[W+2]}}, dmid_ff};
   assign hh_ext   = {{(XW-2*HW-1){dhh_ff[2*HW]}}, dhh_ff};
   assign cross_in = ll_ext + (mid_ext << K) + (hh_ext << (2 * K));

   assign cr_neg  = cross_ff[XW-1];
   assign cr_zero = (cross_ff == '0);
   assign cr_pos  = !cr_neg && !cr_zero;

   always_comb begin
      bound_in  = bound_ff;
      parity_in = parity_ff;
      unique case (c3_ff.op)
         OP_CLEAR: begin
            bound_in  = 1'b0;
            parity_in = 1'b0;
         end
         OP_UP: begin
            if (cr_pos) begin
               parity_in = !parity_ff;
            end else if (cr_zero) begin
               bound_in = 1'b1;
            end
         end
         OP_DOWN: begin
            if (cr_neg) begin
               parity_in = !parity_ff;
            end else if (cr_zero) begin
               bound_in = 1'b1;
            end
         end
         OP_TOUCH: begin
            if (cr_zero) begin
               bound_in = 1'b1;
            end
         end
         OP_BOUND: begin
            bound_in = 1'b1;
         end
         default: begin
         end
      endcase
      priority if (c3_ff.outside) begin
         loc = LOC_OUTSIDE;
      end else if (bound_in) begin
         loc = LOC_BOUNDARY;
      end else if (parity_in) begin
         loc = LOC_INSIDE;
      end else begin
         loc = LOC_OUTSIDE;
      end
      rsp_push = s3_valid_ff && c3_ff.last;
      if (c3_ff.last) begin
         bound_in  = 1'b0;
         parity_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         bound_ff    <= 1'b0;
         parity_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= q_pop;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         if (s3_valid_ff) begin
            bound_ff  <= bound_in;
            parity_ff <= parity_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      c1_ff    <= q_ctrl;
      ll1_ff   <= ll1_in;
      lh1_ff   <= lh1_in;
      hl1_ff   <= hl1_in;
      hh1_ff   <= hh1_in;
      ll2_ff   <= ll2_in;
      lh2_ff   <= lh2_in;
      hl2_ff   <= hl2_in;
      hh2_ff   <= hh2_in;
      c2_ff    <= c1_ff;
      dll_ff   <= dll_in;
      dmid_ff  <= dmid_in;
      dhh_ff   <= dhh_in;
      c3_ff    <= c2_ff;
      cross_ff <= cross_in;
   end

   pipt_queue #(
      .WIDTH ($bits(loc_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (loc),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_location),
      .empty   (rsp_empty),
      .count   (rsp_count)
   );

   `PIPT_ASSERT_IMPLY(a_rsp_room, rsp_push, !rsp_full, "result written into a full queue")
   `PIPT_ASSERT_NEXT(a_issue_enters, q_pop, s1_valid_ff, "issued word missing in stage 1")
   `PIPT_ASSERT_NEXT(a_flags_clear, rsp_push, !bound_ff && !parity_ff, "flags kept after result")

endmodule

>>> rtl/point_in_polygon_tester_core.sv
// ----------------------------------------------------------------------------
// point_in_polygon_tester_core
// Fixed-point point-in-polygon test (Hormann-Agathos) over a word stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// A query is a run of request words: the query point, one or more bounding
// boxes, then ring vertices (each ring starts with first_in_ring and closes by
// repeating its first vertex); the word with last set returns one location
// word: outside, inside or on boundary. The block takes one request word per
// clock whenever req_full is low. The front stage registers the query state and
// classifies each edge in the cycle it is accepted; the word then passes a
// 4-entry edge queue and a three-stage cross-product pipeline (split into
// half-width partial products), whose last stage writes the location of a
// last word into the result queue. Words are issued into the pipeline only
// while the 8-entry result queue has room for all of them, so a stalled
// reader backs up the edge queue and then req_full, never loses a result.
module point_in_polygon_tester_core import pipt_pkg::*; #(
   parameter int COORD_BITS = 32,
   parameter int COUNT_BITS = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   // request side
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [1:0]                    req_kind,
   input  logic signed [COORD_BITS-1:0]  req_coord_x,
   input  logic signed [COORD_BITS-1:0]  req_coord_y,
   input  logic signed [COORD_BITS-1:0]  req_coord_x2,
   input  logic signed [COORD_BITS-1:0]  req_coord_y2,
   input  logic                          req_first_in_ring,
   input  logic [COUNT_BITS-1:0]         req_ring_points,
   input  logic                          req_last,
   // result side
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [1:0]                    rsp_location
);

   localparam int W  = COORD_BITS + 1;   // relative coordinates need a carry bit
   localparam int EW = $bits(ctrl_type) + 4 * W;

   logic             accept;
   logic             edge_full, edge_empty, edge_pop;
   ctrl_type         f_ctrl, h_ctrl;
   logic [W-1:0]     f_u1, f_v1, f_u2, f_v2;
   logic [W-1:0]     h_u1, h_v1, h_u2, h_v2;
   logic [EW-1:0]    edge_wr, edge_rd;

   // the edge queue is the only back-pressure on the request side
   assign req_full = edge_full;
   assign accept   = req_push && !edge_full;

   pipt_front #(
      .COORD_BITS (COORD_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .kind          (req_kind),
      .coord_x       (req_coord_x),
      .coord_y       (req_coord_y),
      .coord_x2      (req_coord_x2),
      .coord_y2      (req_coord_y2),
      .first_in_ring (req_first_in_ring),
      .ring_points   (req_ring_points),
      .last          (req_last),
      .word_ctrl     (f_ctrl),
      .word_u1       (f_u1),
      .word_v1       (f_v1),
      .word_u2       (f_u2),
      .word_v2       (f_v2)
   );

   // every accepted word goes through, so flag updates stay in order
   assign edge_wr = {f_ctrl, f_u1, f_v1, f_u2, f_v2};

   pipt_queue #(
      .WIDTH (EW),
      .DEPTH (EDGE_DEPTH)
   ) u_edge_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (accept),
      .wr_data (edge_wr),
      .full    (edge_full),
      .pop     (edge_pop),
      .rd_data (edge_rd),
      .empty   (edge_empty),
      .count   ()
   );

   assign {h_ctrl, h_u1, h_v1, h_u2, h_v2} = edge_rd;

   pipt_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (edge_empty),
      .q_pop        (edge_pop),
      .q_ctrl       (h_ctrl),
      .q_u1         (h_u1),
      .q_v1         (h_v1),
      .q_u2         (h_u2),
      .q_v2         (h_v2),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_location (rsp_location)
   );

endmodule
